/* hdl/ftpc_pkg.sv */
// ----------------------------------------------------------------------------
// ftpc_pkg: shared types and constants of the frequency threshold purge cache
// Entry layout, cell commands and the widths used by the cell row and control.
// ----------------------------------------------------------------------------
package ftpc_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int HITS_W  = 16;
  localparam int CAP_W   = 5;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CNTD_W  = $clog2(DEPTH + 1);
  localparam int CAPX_W  = (CAP_W > CNTD_W) ? CAP_W : CNTD_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(2);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [HITS_W-1:0] HITS_MAX   = '1;

  typedef enum logic [0:0] {
    REG_CAPACITY  = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_STORE  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_ACCESS,
    CMD_PURGE,
    CMD_COMPACT,
    CMD_SHIFT,
    CMD_INSERT
  } cell_cmd_t;

  typedef struct packed {
    logic                     valid;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] data;
    logic [HITS_W-1:0]        hits;
  } entry_t;

  typedef struct packed {
    cell_cmd_t                cmd;
    logic                     store;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] value;
    logic [THR_W-1:0]         threshold;
  } cell_ctl_t;

endpackage

/* hdl/ftpc_cell.sv */
// ----------------------------------------------------------------------------
// ftpc_cell: one entry of the cache row
// Holds one entry and moves it toward the oldest end of the row on command.
// ----------------------------------------------------------------------------
module ftpc_cell
  import ftpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    up_ent,      // neighbor on the newer side
  input  logic      down_valid,  // neighbor on the older side holds an entry
  input  logic      down_pull,   // older neighbor takes this cell's entry
  output entry_t    ent,
  output logic      pull,
  output logic      match
);

  logic                     valid_r, valid_nxt;
  logic [KEY_W-1:0]         key_r, key_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic [HITS_W-1:0]        hits_r, hits_nxt;

  assign ent   = '{valid: valid_r, key: key_r, data: data_r, hits: hits_r};
  assign pull  = !valid_r && up_ent.valid;
  assign match = valid_r && (key_r == ctl.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    hits_nxt  = hits_r;
    case (ctl.cmd)
      CMD_ACCESS: begin
        if (match) begin
          if (hits_r != HITS_MAX) begin
            hits_nxt = hits_r + 1'b1;
          end
          if (ctl.store) begin
            data_nxt = ctl.value;
          end
        end
      end
      CMD_PURGE: begin
        if (valid_r && (hits_r < ctl.threshold)) begin
          valid_nxt = 1'b0;
        end
      end
      CMD_COMPACT: begin
        // A hole takes the entry above it; the entry that left becomes a hole.
        if (pull) begin
          valid_nxt = 1'b1;
          key_nxt   = up_ent.key;
          data_nxt  = up_ent.data;
          hits_nxt  = up_ent.hits;
        end else if (down_pull) begin
          valid_nxt = 1'b0;
        end
      end
      CMD_SHIFT: begin
        valid_nxt = up_ent.valid;
        key_nxt   = up_ent.key;
        data_nxt  = up_ent.data;
        hits_nxt  = up_ent.hits;
      end
      CMD_INSERT: begin
        if (!valid_r && down_valid) begin
          valid_nxt = 1'b1;
          key_nxt   = ctl.key;
          data_nxt  = ctl.value;
          hits_nxt  = HITS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
    hits_r <= hits_nxt;
  end

endmodule

/* hdl/frequency_threshold_purge_cache.sv */
// ----------------------------------------------------------------------------
// frequency_threshold_purge_cache: fully associative cache with count purge
// Key/value store kept as a row of cells in insertion order, oldest first.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel: in_tuser carries the opcode (lookup or
// store) and in_tdata the key and the store value. Each request yields one
// response on the out_ channel: out_tuser is the hit flag and out_tdata the
// value read, or all ones on a miss and on every store.
// The cfg_ channel writes the capacity in use and the keep threshold; it is
// always ready and is meant to be written only while the cache is idle.
// A lookup or a store to a present key goes from the match state straight to
// the response; an insert into a cache below capacity passes the insert state.
// An insert into a full cache first drops every entry whose count is below
// the threshold and then closes the holes by bubbling entries one cell per
// cycle; if the row is still full, evicting the oldest entry after that is
// a single shift of the whole row. One request is in flight at a time, so
// the compaction walk over the row sets the worst-case rate.
// Reset empties the cache and restores capacity 16 and threshold 2.
// When the receiver stalls, the response waits in the output register and
// the next request is accepted; it finishes up to its write of the response
// and then holds until the output register frees up.
// ----------------------------------------------------------------------------
module frequency_threshold_purge_cache
  import ftpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // [31:0] lookup_key, [63:32] store_value
  input  logic [0:0]        in_tuser,   // [0] opcode
  // Response channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] read_value
  output logic [0:0]        out_tuser,  // [0] hit
  // Configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMPACT,
    ST_INSERT
  } state_t;

  state_t                   state_r;
  logic                     req_store_r;
  logic [KEY_W-1:0]         req_key_r;
  logic signed [DATA_W-1:0] req_value_r;
  logic                     out_valid_r;
  logic                     out_hit_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [CAP_W-1:0]         cap_r;
  logic [THR_W-1:0]         thr_r;

  cell_ctl_t                ctl;
  entry_t                   ents [DEPTH];
  entry_t                   ups  [DEPTH];
  logic [DEPTH-1:0]         pulls;
  logic [DEPTH-1:0]         match_vec;
  logic [DEPTH-1:0]         valids;

  logic                     any_hit;
  logic signed [DATA_W-1:0] hit_data;
  logic                     out_free;
  logic                     resp_done;
  logic                     full;
  logic [CAPX_W-1:0]        cap_ext;
  logic [CAPX_W-1:0]        cap_m1;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  // The response register is loaded in the cycle a request finishes.
  assign resp_done = ((state_r == ST_MATCH) && (any_hit || !req_store_r) && out_free) ||
                     ((state_r == ST_INSERT) && out_free);

  // The row is always packed from cell 0, so the cache is at capacity exactly
  // when the cell at (capacity - 1) holds an entry, capacity clamped to 1 to DEPTH.
  always_comb begin
    cap_ext = CAPX_W'(cap_r);
    if (cap_ext == '0) begin
      cap_m1 = '0;
    end else if (cap_ext > CAPX_W'(DEPTH)) begin
      cap_m1 = CAPX_W'(DEPTH - 1);
    end else begin
      cap_m1 = cap_ext - 1'b1;
    end
  end

  assign full = valids[cap_m1[IDX_W-1:0]];

  // Keys are unique among valid entries, so at most one cell matches.
  always_comb begin
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_vec[i]) begin
        hit_data = hit_data | ents[i].data;
      end
    end
  end
  assign any_hit = |match_vec;

  // Command to the cell row for the current cycle.
  always_comb begin
    ctl.cmd       = CMD_HOLD;
    ctl.store     = req_store_r;
    ctl.key       = req_key_r;
    ctl.value     = req_value_r;
    ctl.threshold = thr_r;
    case (state_r)
      ST_MATCH: begin
        if (any_hit || !req_store_r) begin
          if (out_free) begin
            ctl.cmd = CMD_ACCESS;
          end
        end else if (full) begin
          ctl.cmd = CMD_PURGE;
        end
      end
      ST_COMPACT: begin
        if (|pulls) begin
          ctl.cmd = CMD_COMPACT;
        end else if (full) begin
          ctl.cmd = CMD_SHIFT;
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          ctl.cmd = CMD_INSERT;
        end
      end
      default: begin
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_top
        assign ups[g] = '0;
      end else begin : g_mid
        assign ups[g] = ents[g+1];
      end

      ftpc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .up_ent     (ups[g]),
        .down_valid ((g == 0) ? 1'b1 : valids[(g == 0) ? 0 : g-1]),
        .down_pull  ((g == 0) ? 1'b0 : pulls[(g == 0) ? 0 : g-1]),
        .ent        (ents[g]),
        .pull       (pulls[g]),
        .match      (match_vec[g])
      );

      assign valids[g] = ents[g].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      thr_r       <= THR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CAPACITY:  cap_r <= cfg_data[CAP_W-1:0];
          REG_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end

      if (resp_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (any_hit || !req_store_r) begin
            if (out_free) begin
              state_r <= ST_IDLE;
            end
          end else if (full) begin
            state_r <= ST_COMPACT;
          end else begin
            state_r <= ST_INSERT;
          end
        end
        ST_COMPACT: begin
          if (!(|pulls)) begin
            state_r <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and response payload; no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      req_store_r <= (opcode_t'(in_tuser[0]) == OP_STORE);
      req_key_r   <= in_tdata[31:0];
      req_value_r <= in_tdata[63:32];
    end
    if (state_r == ST_MATCH && (any_hit || !req_store_r) && out_free) begin
      out_hit_r  <= any_hit;
      out_data_r <= (any_hit && !req_store_r) ? hit_data : MISS_VALUE;
    end
    if (state_r == ST_INSERT && out_free) begin
      out_hit_r  <= 1'b0;
      out_data_r <= MISS_VALUE;
    end
  end

endmodule
